// File: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define PML_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PML_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pml_pkg.sv
// Shared types and constants for the pattern match locator.
// No dependencies; used by the top level and its port checker.
package pml_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] count_t;
  typedef logic [63:0] cfg_word_t;

  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_PATTERN_LOW    = 2'd0;
  localparam cfg_idx_t REG_PATTERN_HIGH   = 2'd1;
  localparam cfg_idx_t REG_PATTERN_LENGTH = 2'd2;

  localparam int unsigned PAT_LEN_W     = 5;
  localparam int unsigned PAT_BYTES_MAX = 16;

  localparam byte_t  NEWLINE_BYTE = 8'h0A;
  localparam count_t COUNT_SAT    = 32'hFFFF_FFFF;

endpackage

// File: src/pattern_match_locator.sv
// Streaming non-overlapping substring search: one text byte in, at most one match out.
// Depends on pml_pkg.
//
// Takes one text byte per cycle with no bubbles unless the result register is full and
// not being taken. A byte sits in an input register, where the window of recent bytes is
// compared against the pattern and the counters are updated; a match goes on to the
// result register. The single compare stage between these two registers sets the rate.
// Output backpressure stalls the input only when the result register is full and not
// being taken. The configuration port never stalls; write it only while no item is in
// flight.
module pattern_match_locator #(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pml_pkg::cfg_idx_t   cfg_index,
  input  pml_pkg::cfg_word_t  cfg_data,
  // text in
  input  logic                in_valid,
  output logic                in_ready,
  input  pml_pkg::byte_t      in_text_byte,
  input  logic                in_end_of_text,
  // matches out
  output logic                out_valid,
  input  logic                out_ready,
  output pml_pkg::count_t     out_match_start,
  output pml_pkg::count_t     out_match_end,
  output pml_pkg::count_t     out_line_number,
  output pml_pkg::count_t     out_match_index
);
  import pml_pkg::*;

  localparam int unsigned IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [PAT_LEN_W-1:0] LEN_MAX = PAT_LEN_W'(MAX_PATTERN_BYTES);

  // configuration registers
  cfg_word_t            pat_low_r, pat_high_r;
  logic [PAT_LEN_W-1:0] pat_len_r;

  // input register
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_last_r;

  // per-text state
  byte_t          recent_r [MAX_PATTERN_BYTES];
  count_t         byte_pos_r;
  count_t         nl_total_r;
  logic [IW-1:0]  holdoff_r;
  count_t         matches_r;

  // result register
  logic   out_valid_r;
  count_t start_r, end_r, line_r, index_r;

  // datapath signals
  byte_t                win [MAX_PATTERN_BYTES];
  logic [127:0]         pat_all;
  logic [PAT_LEN_W-1:0] len_eff;
  logic [32:0]          end33, start33;
  logic                 long_enough, blocked, all_eq, hit, s1_go;
  logic [CW-1:0]        nl_in_match;
  logic [IW-1:0]        sel;
  byte_t                tb;
  count_t               nl_total_nxt, line_nxt, start_nxt, end_nxt;

  assign cfg_ready = 1'b1;

  // handshakes: the stage moves when the result register is free or being drained
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  // window and compare
  always_comb begin
    pat_all = {pat_high_r, pat_low_r};
    win[0]  = s1_byte_r;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win[j] = recent_r[j-1];
    end

    if (pat_len_r == '0) begin
      len_eff = PAT_LEN_W'(1);
    end else if (pat_len_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = pat_len_r;
    end

    end33       = {1'b0, byte_pos_r} + 33'd1;
    start33     = end33 - 33'(len_eff);
    long_enough = end33 >= 33'(len_eff);
    blocked     = holdoff_r != '0;

    // pattern byte i lines up with window entry len-1-i
    all_eq      = 1'b1;
    nl_in_match = '0;
    sel         = '0;
    tb          = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (PAT_LEN_W'(i) < len_eff) begin
        sel = IW'(int'(len_eff) - 1 - i);
        tb  = win[sel];
        if (tb != pat_all[i*8 +: 8]) begin
          all_eq = 1'b0;
        end
        if (tb == NEWLINE_BYTE) begin
          nl_in_match = nl_in_match + CW'(1);
        end
      end
    end

    hit = s1_valid_r && !blocked && long_enough && all_eq;

    if (s1_byte_r == NEWLINE_BYTE && nl_total_r != COUNT_SAT) begin
      nl_total_nxt = nl_total_r + 32'd1;
    end else begin
      nl_total_nxt = nl_total_r;
    end

    // newlines inside the match do not count toward the line
    line_nxt  = (nl_total_nxt == COUNT_SAT) ? COUNT_SAT : nl_total_nxt - 32'(nl_in_match);
    start_nxt = start33[32] ? COUNT_SAT : start33[31:0];
    end_nxt   = end33[32] ? COUNT_SAT : end33[31:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= PAT_LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pat_low_r  <= cfg_data;
        REG_PATTERN_HIGH:   pat_high_r <= cfg_data;
        REG_PATTERN_LENGTH: pat_len_r  <= cfg_data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_end_of_text;
    end
  end

  // byte history; only entries inside the current length are ever compared
  always_ff @(posedge clk) begin
    if (s1_go) begin
      recent_r[0] <= s1_byte_r;
      for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
        recent_r[j] <= recent_r[j-1];
      end
    end
  end

  // per-text counters, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      nl_total_r <= '0;
      holdoff_r  <= '0;
      matches_r  <= '0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        byte_pos_r <= '0;
        nl_total_r <= '0;
        holdoff_r  <= '0;
        matches_r  <= '0;
      end else begin
        byte_pos_r <= (byte_pos_r == COUNT_SAT) ? COUNT_SAT : byte_pos_r + 32'd1;
        nl_total_r <= nl_total_nxt;
        if (blocked) begin
          holdoff_r <= holdoff_r - IW'(1);
        end else if (hit) begin
          holdoff_r <= IW'(len_eff - PAT_LEN_W'(1));
        end
        if (hit && matches_r != COUNT_SAT) begin
          matches_r <= matches_r + 32'd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= hit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && hit) begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      line_r  <= line_nxt;
      index_r <= matches_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = start_r;
  assign out_match_end   = end_r;
  assign out_line_number = line_r;
  assign out_match_index = index_r;

endmodule

// File: src/pml_checker.sv
// Port-level checks for the pattern match locator, bound to the top level.
// Depends on pml_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pml_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input pml_pkg::cfg_idx_t   cfg_index,
  input pml_pkg::cfg_word_t  cfg_data,
  input logic                in_valid,
  input logic                in_ready,
  input pml_pkg::byte_t      in_text_byte,
  input logic                in_end_of_text,
  input logic                out_valid,
  input logic                out_ready,
  input pml_pkg::count_t     out_match_start,
  input pml_pkg::count_t     out_match_end,
  input pml_pkg::count_t     out_line_number,
  input pml_pkg::count_t     out_match_index
);
  import pml_pkg::*;

  // a match spans at most the longest pattern and never ends at offset zero
  `PML_ASSERT(a_span, out_valid |-> (out_match_end - out_match_start) <= 32'(PAT_BYTES_MAX) && out_match_end != '0, "match span out of range")

  // a stalled match item holds its start and its index
  `PML_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_match_start) && $stable(out_match_index), "stalled match item changed")

  // no match item comes out of reset
  `PML_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid, "match item valid after reset")

  // configuration writes are never stalled
  `PML_ASSERT(a_cfg, cfg_valid |-> cfg_ready, "configuration write stalled")

endmodule

bind pattern_match_locator pml_checker u_pml_checker (.*);
